FILE: hdl/stb_pkg.sv
// Shared types and constants for the software timer bank.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stb_pkg;

  // Command codes carried in the cmd field of an input transaction
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ARM    = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  timer_index;
    logic [15:0] delay_ticks;
    logic [15:0] reload_ticks;
    logic [7:0]  message_id;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [2:0] expired_index;
    logic [7:0] expired_message;
    logic       last_expiry;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic scan_go;  // current scan entry is consumed, advance the pointer
    logic flush;    // move the held expiry to the output as the final one
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic tick_cmd;    // pending input is a tick
    logic match;       // scanned entry expires on this tick
    logic pend_valid;  // an expiry is held back waiting for its successor
    logic out_free;    // output register can take a new result this cycle
    logic scan_last;   // pointer is on the highest timer
  } stat_t;

endpackage

FILE: hdl/stb_ctrl.sv
// Sequencer for the timer bank: accepts transactions and steps the tick scan.
// Depends on stb_pkg for the command and status structs.
`timescale 1ns / 1ps

module stb_ctrl import stb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  stat_t    stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  assign in_stall = in_stall_r;

  // Next state and per-cycle commands
  always_comb begin
    state_nxt    = state_r;
    in_stall_nxt = in_stall_r;
    cmd          = '0;
    cmd.accept   = in_valid && !in_stall_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && stat.tick_cmd) begin
          state_nxt    = ST_CHECK;
          in_stall_nxt = 1'b1;
        end
      end
      ST_CHECK: begin
        // a second match has to push the held one out first
        if (!(stat.match && stat.pend_valid && !stat.out_free)) begin
          cmd.scan_go = 1'b1;
          if (stat.scan_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt    = ST_IDLE;
          in_stall_nxt = 1'b0;
        end else if (stat.out_free) begin
          cmd.flush    = 1'b1;
          state_nxt    = ST_IDLE;
          in_stall_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_stall_nxt = 1'b0;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

endmodule

FILE: hdl/stb_datapath.sv
// Timer storage, tick counter, scan pointer, held expiry and output register.
// Depends on stb_pkg for transaction, command and status types.
`timescale 1ns / 1ps

module stb_datapath import stb_pkg::*; #(
  parameter int NUM_TIMERS = 8,
  parameter int TIME_BITS  = 16,
  parameter int MSG_BITS   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctl_cmd_t  cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [TIME_BITS-1:0] reload;
    logic [MSG_BITS-1:0]  msg;
  } entry_t;

  // Timer table: one write and one registered read per cycle
  entry_t mem [NUM_TIMERS];
  entry_t rd_r;

  logic [NUM_TIMERS-1:0] active_r;
  logic [TIME_BITS-1:0]  tick_r;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic                  pend_valid_r;
  logic [IDX_W-1:0]      pend_idx_r;
  logic [MSG_BITS-1:0]   pend_msg_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  // Input decode
  logic [31:0]          in_idx_w;
  logic [IDX_W-1:0]     in_idx;
  logic                 in_idx_ok;
  logic [TIME_BITS-1:0] in_delay, in_reload;
  logic [MSG_BITS-1:0]  in_msg;
  logic                 do_tick, do_arm, do_cancel;

  assign in_idx_w  = 32'(in_data.timer_index);
  assign in_idx    = IDX_W'(in_idx_w);
  assign in_idx_ok = in_idx_w < 32'(NUM_TIMERS);
  assign in_delay  = TIME_BITS'(32'(in_data.delay_ticks));
  assign in_reload = TIME_BITS'(32'(in_data.reload_ticks));
  assign in_msg    = MSG_BITS'(16'(in_data.message_id));
  assign do_tick   = cmd.accept && (in_data.cmd == CMD_TICK);
  assign do_arm    = cmd.accept && (in_data.cmd == CMD_ARM) && in_idx_ok;
  assign do_cancel = cmd.accept && (in_data.cmd == CMD_CANCEL) && in_idx_ok;

  // Scan compare on the registered entry
  logic match, reload_nz, scan_last, hit;
  assign match     = active_r[ptr_r] && (rd_r.expiry == tick_r);
  assign reload_nz = |rd_r.reload;
  assign scan_last = ptr_r == IDX_W'(NUM_TIMERS - 1);
  assign hit       = cmd.scan_go && match;

  // Table write: arm, or re-arm of a periodic timer
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = rd_r;
    if (do_arm) begin
      mem_we           = 1'b1;
      mem_waddr        = in_idx;
      mem_wdata.expiry = tick_r + in_delay;
      mem_wdata.reload = in_reload;
      mem_wdata.msg    = in_msg;
    end else if (hit && reload_nz) begin
      mem_we           = 1'b1;
      mem_wdata.expiry = tick_r + rd_r.reload;
    end
  end

  // Scan pointer doubles as the read address
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.accept) begin
      ptr_nxt = '0;
    end else if (cmd.scan_go && !scan_last) begin
      ptr_nxt = ptr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[ptr_nxt];
  end

  // Output formatting of the held expiry
  logic        load_out;
  logic [15:0] pend_msg_w;
  out_item_t   out_load;

  assign load_out   = (hit && pend_valid_r) || cmd.flush;
  assign pend_msg_w = 16'(pend_msg_r);

  always_comb begin
    out_load.expired_index   = 3'(32'(pend_idx_r));
    out_load.expired_message = pend_msg_w[7:0];
    out_load.last_expiry     = cmd.flush;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      tick_r       <= '0;
      ptr_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (do_tick) begin
        tick_r <= tick_r + TIME_BITS'(1);
      end
      if (do_arm) begin
        active_r[in_idx] <= 1'b1;
      end else if (do_cancel) begin
        active_r[in_idx] <= 1'b0;
      end else if (hit && !reload_nz) begin
        active_r[ptr_r] <= 1'b0;
      end
      if (hit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (hit) begin
      pend_idx_r <= ptr_r;
      pend_msg_r <= rd_r.msg;
    end
    if (load_out) begin
      out_data_r <= out_load;
    end
  end

  assign stat.tick_cmd   = in_data.cmd == CMD_TICK;
  assign stat.match      = match;
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.scan_last  = scan_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/software_timer_bank.sv
// Top level of the software timer bank: controller plus datapath.
// Depends on stb_pkg, stb_ctrl and stb_datapath.
`timescale 1ns / 1ps

// A bank of NUM_TIMERS one-shot or periodic timers. A tick transaction
// advances the tick counter and then scans the timers from index 0 up,
// one timer per cycle through the single read port of the timer table
// while the scan is not held by a second match waiting for a stalled
// result to leave, emitting one result per expiring timer with
// last_expiry set on the final one. A tick is accepted, scanned and then
// its last result flushed; in_stall is high from the cycle after the
// accept until the flush, and longer while the result channel stalls; a
// tick with no expiry still takes the full scan. Arm, cancel and unused
// commands never stall the input and can follow one another back to back.
// Stored expiry and reload values are TIME_BITS wide and wrap modulo
// 2^TIME_BITS; messages are kept at MSG_BITS.
module software_timer_bank import stb_pkg::*; #(
  parameter int NUM_TIMERS = 8,
  parameter int TIME_BITS  = 16,
  parameter int MSG_BITS   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_cmd_t ctl_cmd;
  stat_t    dp_stat;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  stb_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS),
    .MSG_BITS   (MSG_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/stb_checker.sv
// Port-level assertions for the software timer bank, bound to the top level.
// Depends on stb_pkg for the transaction types.
`timescale 1ns / 1ps

module stb_checker import stb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A tick transaction starts a scan, so the input stalls next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_TICK) |=> in_stall)
    else $error("tick transaction did not start a scan");

  // Arm, cancel and unused commands do not stall the input afterwards
  a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd != CMD_TICK) |=> !in_stall)
    else $error("non-tick transaction stalled the input");

  // A non-final expiry is always followed by more of the same tick
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_expiry |-> in_stall)
    else $error("non-final expiry shown while idle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);

FILE: tb/sv/software_timer_bank_checker.sv
// Checker for the software timer bank: watches both channels, predicts the
// expiries of every accepted tick and compares them with the results.
// Depends on stb_pkg.
`timescale 1ns / 1ps

module software_timer_bank_checker import stb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);

  localparam int TIMERS = 8;

  // Shadow copy of the timer table
  logic [15:0] tick_now;
  logic        armed  [TIMERS];
  logic [15:0] due_at [TIMERS];
  logic [15:0] period [TIMERS];
  logic [7:0]  tag    [TIMERS];

  // Expiries predicted but not yet seen on the result channel
  out_item_t expiry_q[$];

  // Apply one input transaction to the shadow table, queueing its expiries
  task automatic apply_command(input in_item_t item);
    out_item_t hit;
    int        hits;
    hits = 0;
    case (item.cmd)
      CMD_TICK: begin
        tick_now = tick_now + 16'd1;
        // scan from timer 0 upward, same order as the block
        for (int t = 0; t < TIMERS; t++) begin
          if (armed[t] && due_at[t] == tick_now) begin
            hit.expired_index   = 3'(t);
            hit.expired_message = tag[t];
            hit.last_expiry     = 1'b0;
            expiry_q.push_back(hit);
            hits++;
            if (period[t] != 16'd0) begin
              due_at[t] = tick_now + period[t];
            end else begin
              armed[t] = 1'b0;
            end
          end
        end
        // flag the final expiry of this tick
        if (hits > 0) begin
          hit = expiry_q.pop_back();
          hit.last_expiry = 1'b1;
          expiry_q.push_back(hit);
        end
      end
      CMD_ARM: begin
        if (item.timer_index < TIMERS) begin
          armed[item.timer_index]  = 1'b1;
          due_at[item.timer_index] = tick_now + item.delay_ticks;
          period[item.timer_index] = item.reload_ticks;
          tag[item.timer_index]    = item.message_id;
        end
      end
      CMD_CANCEL: begin
        if (item.timer_index < TIMERS) begin
          armed[item.timer_index] = 1'b0;
        end
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  // One field compare; reports and counts a mismatch
  task automatic check_field(input string field, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare results first, then predict from the input taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      tick_now = '0;
      for (int t = 0; t < TIMERS; t++) begin
        armed[t]  = 1'b0;
        due_at[t] = '0;
        period[t] = '0;
        tag[t]    = '0;
      end
      expiry_q.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expiry_q.size() == 0) begin
          $display("%0t: unexpected expiry, expected none, actual index %0d",
                   $time, out_data.expired_index);
          $display("%0t:   actual message %0d last %0b",
                   $time, out_data.expired_message, out_data.last_expiry);
          mismatches++;
        end else begin
          want = expiry_q.pop_front();
          check_field("expired_index", want.expired_index, out_data.expired_index);
          check_field("expired_message", want.expired_message, out_data.expired_message);
          check_field("last_expiry", want.last_expiry, out_data.last_expiry);
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(in_data);
      end
      outstanding <= expiry_q.size();
    end
  end

endmodule

FILE: tb/sv/software_timer_bank_tb.sv
// Testbench top for the software timer bank: clock, reset, stimulus and
// verdict. Depends on stb_pkg, software_timer_bank and the checker module.
`timescale 1ns / 1ps

module software_timer_bank_tb import stb_pkg::*; ();

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 400;
  localparam int         EARLY_TICKS  = 40;
  localparam int         DRAIN_LIMIT  = 20000;
  localparam int         IN_W         = $bits(in_item_t);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  bit no_gaps = 1'b0;

  software_timer_bank dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  software_timer_bank_checker checker_inst (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one transaction, hold it until taken, then maybe go idle
  task automatic send(input in_item_t item);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tick_once();
    in_item_t item;
    item = in_item_t'(IN_W'({$urandom, $urandom}));
    item.cmd = CMD_TICK;
    send(item);
  endtask

  task automatic arm(input logic [2:0] idx, input logic [15:0] delay,
                     input logic [15:0] reload, input logic [7:0] msg);
    in_item_t item;
    item.cmd          = CMD_ARM;
    item.timer_index  = idx;
    item.delay_ticks  = delay;
    item.reload_ticks = reload;
    item.message_id   = msg;
    send(item);
  endtask

  // Non-arm command with all other fields set, which must be ignored
  task automatic issue(input logic [1:0] cmd, input logic [2:0] idx);
    in_item_t item;
    item = '1;
    item.cmd = cmd;
    item.timer_index = idx;
    send(item);
  endtask

  // Result side back-pressure: open stretches, some long, then stalls
  initial begin
    int stall_cycles;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      stall_cycles = gap_len();
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t item;
    int       count;
    int       r;
    int       waited;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, ignored codes, one-shot, same-tick pair, re-arm
    tick_once();
    issue(CMD_UNUSED, 3'd7);
    issue(CMD_CANCEL, 3'd4);
    arm(3'd0, 16'd1, 16'd0, 8'hFF);
    tick_once();
    tick_once();
    arm(3'd7, 16'd2, 16'd3, 8'h00);
    arm(3'd3, 16'd2, 16'd0, 8'hA5);
    tick_once();
    tick_once();
    arm(3'd7, 16'd1, 16'd0, 8'h5A);
    tick_once();
    // armed then cancelled before it is due
    arm(3'd5, 16'd1, 16'd2, 8'h42);
    issue(CMD_CANCEL, 3'd5);
    tick_once();
    // every timer expires on one tick
    for (int t = 0; t < 8; t++) begin
      arm(3'(t), 16'd1, 16'd0, 8'(8'h11 * t));
    end
    tick_once();

    // Zero delay, full-range delay and reload: none of these fire early,
    // only the one-tick timer reports once
    no_gaps = 1'b1;
    arm(3'd0, 16'd0, 16'd0, 8'h11);
    arm(3'd3, 16'd0, 16'd5, 8'h33);
    arm(3'd1, 16'hFFFF, 16'hFFFF, 8'h22);
    arm(3'd2, 16'd1, 16'hFFFF, 8'h44);
    arm(3'd6, 16'd300, 16'h8000, 8'h66);
    repeat (EARLY_TICKS) tick_once();
    for (int t = 0; t < 8; t++) begin
      issue(CMD_CANCEL, 3'(t));
    end
    no_gaps = 1'b0;

    // Random: mostly short delays so timers fire, occasional full range
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if (count % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      item = in_item_t'(IN_W'({$urandom, $urandom}));
      r = $urandom_range(0, 99);
      if (r < 45) begin
        item.cmd = CMD_TICK;
      end else if (r < 80) begin
        item.cmd = CMD_ARM;
        r = $urandom_range(0, 9);
        if (r < 8) item.delay_ticks = 16'($urandom_range(1, 12));
        else if (r == 8) item.delay_ticks = '0;
        r = $urandom_range(0, 9);
        if (r < 4) item.reload_ticks = '0;
        else if (r < 9) item.reload_ticks = 16'($urandom_range(1, 10));
      end else if (r < 96) begin
        item.cmd = CMD_CANCEL;
      end else begin
        item.cmd = CMD_UNUSED;
      end
      send(item);
      if (item.cmd != CMD_UNUSED) count++;
    end
    in_valid <= 1'b0;

    // Drain, then give any stray result time to show up
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);

    if (outstanding != 0) begin
      $display("%0t: %0d expected expiries never arrived", $time, outstanding);
    end
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
